// ----- rtl/npc_pkg.sv -----
// Shared types, constants and codes for the nearest palette color unit.
`timescale 1ns / 1ps

package npc_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CHAN_W      = 16;
    localparam int ENTRY_W     = 3 * CHAN_W;
    localparam int SIZE_W      = 9;
    localparam int SQ_W        = 17;
    localparam int DIST_W      = 18;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic              op;
        logic [7:0]        entry_index;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } cmd_t;

    typedef struct packed {
        logic [7:0]        best_index;
        logic [DIST_W-1:0] best_distance;
    } result_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] index;
        logic              last;
    } tag_t;

endpackage

// ----- rtl/npc_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module npc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/npc_dist.sv -----
// Distance stage: shifted channel differences, registered squares and their sum.
`timescale 1ns / 1ps

module npc_dist (
    input  logic                           clk,
    input  logic                           rst_n,
    input  npc_pkg::tag_t                  tag_in,
    input  logic [npc_pkg::ENTRY_W-1:0]    entry,
    input  logic [npc_pkg::ENTRY_W-1:0]    query,
    output npc_pkg::tag_t                  tag_out,
    output logic [npc_pkg::DIST_W-1:0]     distance
);

    logic signed [8:0]               d_r;
    logic signed [8:0]               d_g;
    logic signed [8:0]               d_b;
    logic [npc_pkg::SQ_W-1:0]        sq_r_reg;
    logic [npc_pkg::SQ_W-1:0]        sq_g_reg;
    logic [npc_pkg::SQ_W-1:0]        sq_b_reg;
    npc_pkg::tag_t                   tag_reg;

    function automatic logic signed [8:0] shifted_diff(
        input logic [npc_pkg::CHAN_W-1:0] a,
        input logic [npc_pkg::CHAN_W-1:0] b
    );
        logic [npc_pkg::CHAN_W:0] diff;
        diff = {1'b0, a} - {1'b0, b};
        return diff[npc_pkg::CHAN_W:8];
    endfunction

    function automatic logic [npc_pkg::SQ_W-1:0] square(input logic signed [8:0] d);
        logic signed [17:0] p;
        p = d * d;
        return p[npc_pkg::SQ_W-1:0];
    endfunction

    assign d_r = shifted_diff(entry[47:32], query[47:32]);
    assign d_g = shifted_diff(entry[31:16], query[31:16]);
    assign d_b = shifted_diff(entry[15:0],  query[15:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_r_reg <= square(d_r);
        sq_g_reg <= square(d_g);
        sq_b_reg <= square(d_b);
    end

    assign tag_out  = tag_reg;
    assign distance = npc_pkg::DIST_W'(sq_r_reg) + npc_pkg::DIST_W'(sq_g_reg)
                    + npc_pkg::DIST_W'(sq_b_reg);

endmodule

// ----- rtl/nearest_palette_color_unit.sv -----
// Top level of the nearest palette color unit: palette memory, scan control, best tracking.
//
//  Channel   Direction  Signals                     Transfer
//  command   in         start, busy, cmd            start && !busy
//  result    out        result_valid, result        one-cycle strobe
//  config    in         cfg_wr_en, cfg_wr_data      cfg_wr_en
//
// A load transaction leaves busy low.
// A query reads one palette entry per cycle from the memory's single read port, over the
// effective palette size, and raises result_valid once the last entry has passed the distance stage.
// Reset sets the palette size to 256; palette contents stay undefined until loaded.
// The receiver cannot stall; each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module nearest_palette_color_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  npc_pkg::cmd_t                  cmd,
    output logic                           result_valid,
    output npc_pkg::result_t               result,
    input  logic                           cfg_wr_en,
    input  logic [npc_pkg::SIZE_W-1:0]     cfg_wr_data
);

    npc_pkg::state_t                    state_reg;
    npc_pkg::state_t                    state_next;
    logic [npc_pkg::SIZE_W-1:0]         size_reg;
    logic [npc_pkg::ADDR_W-1:0]         addr_reg;
    logic [npc_pkg::ADDR_W-1:0]         addr_next;
    logic [npc_pkg::ADDR_W-1:0]         last_reg;
    logic [npc_pkg::ADDR_W-1:0]         last_next;
    logic [npc_pkg::ENTRY_W-1:0]        query_reg;
    npc_pkg::tag_t                      tag1_reg;
    npc_pkg::tag_t                      tag1_next;
    npc_pkg::tag_t                      tag2;
    logic [npc_pkg::DIST_W-1:0]         dist2;
    logic [npc_pkg::DIST_W-1:0]         best_dist_reg;
    logic [npc_pkg::ADDR_W-1:0]         best_idx_reg;
    logic [npc_pkg::DIST_W-1:0]         best_dist_next;
    logic [npc_pkg::ADDR_W-1:0]         best_idx_next;
    npc_pkg::result_t                   result_reg;
    logic                               result_valid_reg;
    logic                               accept;
    logic                               query_accept;
    logic                               ram_we;
    logic                               ram_re;
    logic [npc_pkg::ENTRY_W-1:0]        ram_rdata;

    assign accept       = start && !busy;
    assign query_accept = accept && (cmd.op == npc_pkg::OP_QUERY);
    assign ram_we       = accept && (cmd.op == npc_pkg::OP_LOAD)
                        && (32'(cmd.entry_index) < npc_pkg::MAX_ENTRIES);

    always_comb
    begin
        priority if (size_reg == '0)
        begin
            last_next = '0;
        end
        else if (32'(size_reg) > npc_pkg::MAX_ENTRIES)
        begin
            last_next = npc_pkg::ADDR_W'(npc_pkg::MAX_ENTRIES - 1);
        end
        else
        begin
            last_next = npc_pkg::ADDR_W'(size_reg - 9'd1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            npc_pkg::ST_IDLE:
            begin
                if (query_accept)
                begin
                    state_next = npc_pkg::ST_SCAN;
                end
            end
            npc_pkg::ST_SCAN:
            begin
                if (addr_reg == last_reg)
                begin
                    state_next = npc_pkg::ST_DRAIN;
                end
            end
            npc_pkg::ST_DRAIN:
            begin
                if (tag2.valid && tag2.last)
                begin
                    state_next = npc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = npc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy   = 1'b1;
        ram_re = 1'b0;
        unique case (state_reg)
            npc_pkg::ST_IDLE:
            begin
                busy = 1'b0;
            end
            npc_pkg::ST_SCAN:
            begin
                ram_re = 1'b1;
            end
            npc_pkg::ST_DRAIN:
            begin
                ram_re = 1'b0;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    assign addr_next       = (state_reg == npc_pkg::ST_SCAN) ? addr_reg + 1'b1 : '0;
    assign tag1_next.valid = ram_re;
    assign tag1_next.index = addr_reg;
    assign tag1_next.last  = (addr_reg == last_reg);

    always_comb
    begin
        best_dist_next = best_dist_reg;
        best_idx_next  = best_idx_reg;
        if (tag2.valid && ((tag2.index == '0) || (dist2 < best_dist_reg)))
        begin
            best_dist_next = dist2;
            best_idx_next  = tag2.index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= npc_pkg::ST_IDLE;
            size_reg         <= npc_pkg::SIZE_RESET;
            addr_reg         <= '0;
            tag1_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            addr_reg         <= addr_next;
            tag1_reg         <= tag1_next;
            result_valid_reg <= tag2.valid && tag2.last;
            if (cfg_wr_en)
            begin
                size_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_accept)
        begin
            query_reg <= {cmd.red, cmd.green, cmd.blue};
            last_reg  <= last_next;
        end
        best_dist_reg <= best_dist_next;
        best_idx_reg  <= best_idx_next;
        if (tag2.valid && tag2.last)
        begin
            result_reg.best_index    <= 8'(best_idx_next);
            result_reg.best_distance <= best_dist_next;
        end
    end

    npc_ram #(
        .WIDTH(npc_pkg::ENTRY_W),
        .DEPTH(npc_pkg::MAX_ENTRIES)
    ) u_palette (
        .clk  (clk),
        .we   (ram_we),
        .waddr(npc_pkg::ADDR_W'(cmd.entry_index)),
        .wdata({cmd.red, cmd.green, cmd.blue}),
        .re   (ram_re),
        .raddr(addr_reg),
        .rdata(ram_rdata)
    );

    npc_dist u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (tag1_reg),
        .entry   (ram_rdata),
        .query   (query_reg),
        .tag_out (tag2),
        .distance(dist2)
    );

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    a_result_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == npc_pkg::ST_DRAIN))
        else $error("Result strobe without a finished scan.");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("Result strobe lasted more than one cycle.");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        query_accept |=> busy && (state_reg == npc_pkg::ST_SCAN))
        else $error("Query transaction did not start a scan.");

    a_no_write_during_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> !ram_we)
        else $error("Palette write overlapped a scan read.");

endmodule

// ----- verif/tb_nearest_palette_color_unit.sv -----
// Self-checking testbench for the nearest palette color unit, with its own palette search predictor.
`timescale 1ns / 1ps

module tb_nearest_palette_color_unit;

    import npc_pkg::*;

    localparam int ITEM_TARGET = 700;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 8;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    cmd_t                 cmd         = '0;
    logic                 result_valid;
    result_t              result;
    logic                 cfg_wr_en   = 1'b0;
    logic [SIZE_W-1:0]    cfg_wr_data = '0;

    cmd_t                 pending_cmds[$];
    result_t              expected_results[$];

    logic [CHAN_W-1:0]    shadow_red   [MAX_ENTRIES];
    logic [CHAN_W-1:0]    shadow_green [MAX_ENTRIES];
    logic [CHAN_W-1:0]    shadow_blue  [MAX_ENTRIES];
    logic [SIZE_W-1:0]    shadow_size = SIZE_RESET;

    logic [ENTRY_W-1:0]   plan_color  [MAX_ENTRIES];
    bit                   plan_loaded [MAX_ENTRIES];
    logic [SIZE_W-1:0]    plan_size = SIZE_RESET;

    int                   sender_idle_pct = 32;
    int                   item_count      = 0;
    int                   mismatch_count  = 0;
    int unsigned          cycle_count     = 0;

    nearest_palette_color_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("nearest_palette_color_unit: mismatch");
            $finish;
        end
    end

    function automatic int effective_size(logic [SIZE_W-1:0] size_val);
        if (size_val == 0)
            return 1;
        else if (size_val > MAX_ENTRIES)
            return MAX_ENTRIES;
        else
            return int'(size_val);
    endfunction

    // Floor of the channel difference divided by 256, squared.
    function automatic int channel_error_sq(logic [CHAN_W-1:0] entry, logic [CHAN_W-1:0] query);
        int step;
        step = (int'(entry) - int'(query)) >>> 8;
        return step * step;
    endfunction

    function automatic void apply_command(cmd_t c);
        int      n;
        int      distance_sum;
        int      best;
        int      best_j;
        result_t r;
        if (c.op == OP_LOAD)
        begin
            shadow_red[c.entry_index]   = c.red;
            shadow_green[c.entry_index] = c.green;
            shadow_blue[c.entry_index]  = c.blue;
        end
        else
        begin
            n      = effective_size(shadow_size);
            best   = 32'h7fffffff;
            best_j = 0;
            for (int j = 0; j < n; j++)
            begin
                distance_sum = channel_error_sq(shadow_red[j], c.red)
                             + channel_error_sq(shadow_green[j], c.green)
                             + channel_error_sq(shadow_blue[j], c.blue);
                if (distance_sum < best)
                begin
                    best   = distance_sum;
                    best_j = j;
                end
            end
            r.best_index    = best_j[7:0];
            r.best_distance = best[DIST_W-1:0];
            expected_results.push_back(r);
        end
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR t=%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Command driver: a transaction is accepted when start is high and busy is low.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
                apply_command(cmd);
            if (!start || !busy)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    start <= 1'b1;
                    cmd   <= pending_cmds.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result index %0d distance %0d",
                                          result.best_index, result.best_distance));
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.best_index !== want.best_index)
                    report_mismatch($sformatf("best_index %0d, predicted %0d",
                                              result.best_index, want.best_index));
                if (result.best_distance !== want.best_distance)
                    report_mismatch($sformatf("best_distance %0d, predicted %0d",
                                              result.best_distance, want.best_distance));
            end
        end
    end

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || start || busy || expected_results.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_palette_size(logic [SIZE_W-1:0] size_val);
        wait_drained();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= size_val;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        shadow_size = size_val;
        plan_size   = size_val;
    endtask

    task automatic push_load(int idx, logic [ENTRY_W-1:0] rgb);
        cmd_t c;
        c.op          = OP_LOAD;
        c.entry_index = idx[7:0];
        {c.red, c.green, c.blue} = rgb;
        pending_cmds.push_back(c);
        plan_color[idx[7:0]]  = rgb;
        plan_loaded[idx[7:0]] = 1'b1;
        item_count++;
    endtask

    task automatic push_query(logic [ENTRY_W-1:0] rgb);
        cmd_t c;
        c.op          = OP_QUERY;
        c.entry_index = 8'($urandom);
        {c.red, c.green, c.blue} = rgb;
        pending_cmds.push_back(c);
        item_count++;
    endtask

    function automatic logic [CHAN_W-1:0] extreme_channel();
        return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
    endfunction

    function automatic logic [ENTRY_W-1:0] random_color();
        return {16'($urandom), 16'($urandom), 16'($urandom)};
    endfunction

    task automatic run_phase(logic [SIZE_W-1:0] size_val, int n_ops);
        int                 n;
        int                 roll;
        int                 j;
        logic [ENTRY_W-1:0] base;
        logic [ENTRY_W-1:0] rgb;
        set_palette_size(size_val);
        n = effective_size(plan_size);
        for (int i = 0; i < n; i++)
            if (!plan_loaded[i])
                push_load(i, random_color());
        repeat (n_ops)
        begin
            roll = $urandom_range(99);
            j    = $urandom_range(n - 1, 0);
            base = plan_color[j];
            if (roll < 40)
            begin
                if ($urandom_range(99) < 20)
                    rgb = base;
                else if ($urandom_range(99) < 12)
                    rgb = {extreme_channel(), extreme_channel(), extreme_channel()};
                else
                    rgb = random_color();
                if ($urandom_range(99) < 70)
                    push_load($urandom_range(n - 1, 0), rgb);
                else
                    push_load($urandom_range(MAX_ENTRIES - 1, 0), rgb);
            end
            else
            begin
                roll = $urandom_range(99);
                if (roll < 25)
                    rgb = base;
                else if (roll < 55)
                    rgb = {16'(base[47:32] + $urandom_range(1023) - 512),
                           16'(base[31:16] + $urandom_range(1023) - 512),
                           16'(base[15:0]  + $urandom_range(1023) - 512)};
                else if (roll < 65)
                    rgb = {extreme_channel(), extreme_channel(), extreme_channel()};
                else
                    rgb = random_color();
                push_query(rgb);
            end
        end
    endtask

    initial
    begin
        int phase;
        int roll;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            shadow_red[i]   = '0;
            shadow_green[i] = '0;
            shadow_blue[i]  = '0;
            plan_color[i]   = '0;
            plan_loaded[i]  = 1'b0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A size of zero searches entry 0 only.
        set_palette_size(9'd0);
        push_load(0, 48'h0000_0000_0000);
        push_query(48'h0000_0000_0000);
        push_query(48'hFFFF_FFFF_FFFF);
        push_query(48'h00FF_0100_0001);
        push_load(0, 48'hFFFF_FFFF_FFFF);
        push_query(48'h0000_0000_0000);
        push_query(48'hFF00_FF00_FF00);
        push_query(48'hFEFF_FEFF_FEFF);

        set_palette_size(9'd1);
        push_query(48'h7FFF_8000_7FFF);

        // Entries 1 and 2 are equal, so the lower index must win.
        set_palette_size(9'd4);
        push_load(1, 48'h1000_2000_3000);
        push_load(2, 48'h1000_2000_3000);
        push_load(3, 48'h8000_8000_8000);
        push_query(48'h1000_2000_3000);
        push_query(48'h8050_8000_80FF);
        push_load(255, 48'hAAAA_5555_AAAA);
        push_query(48'h0000_0000_0000);

        phase = 0;
        while (item_count < ITEM_TARGET)
        begin
            sender_idle_pct = (phase == 3) ? 0 : 32;
            if (phase == 2)
            begin
                run_phase(9'd511, 4);
            end
            else if (phase == 5)
            begin
                run_phase(9'd256, 3);
            end
            else if (phase == 3)
            begin
                run_phase(9'($urandom_range(24, 1)), 90);
            end
            else
            begin
                roll = $urandom_range(99);
                if (roll < 5)
                    run_phase(9'd0, 12);
                else if (roll < 10)
                    run_phase(9'($urandom_range(511, 257)), 4);
                else if (roll < 18)
                    run_phase(9'($urandom_range(255, 25)), 6);
                else
                    run_phase(9'($urandom_range(24, 1)), $urandom_range(40, 20));
            end
            phase++;
        end

        wait_drained();
        if (mismatch_count == 0)
            $display("nearest_palette_color_unit: match");
        else
            $display("nearest_palette_color_unit: mismatch");
        $finish;
    end

endmodule
